// ===== sv/bsw_pkg.sv =====
// Shared types and constants for the BAR sizing and window allocator.
// Holds the beat structs, status codes and configuration register indexes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bsw_pkg;

    // Result status codes
    localparam logic [2:0] ST_ABSENT = 3'd0;
    localparam logic [2:0] ST_IO     = 3'd1;
    localparam logic [2:0] ST_WIN32  = 3'd2;
    localparam logic [2:0] ST_WIN64  = 3'd3;
    localparam logic [2:0] ST_NOROOM = 3'd4;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_WIN32_CPU_BASE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIN32_PCI_BASE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WIN32_LENGTH   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WIN64_CPU_BASE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WIN64_PCI_BASE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_WIN64_LENGTH   = 3'd5;

    // Memory BAR type field value for a 64-bit register
    localparam logic [1:0] MEM_TYPE_64 = 2'd2;

    typedef struct packed {
        logic [3:0]  type_bits;
        logic [31:0] probe_low;
        logic [31:0] probe_high;
    } bsw_in_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [63:0] pci_address;
        logic [63:0] cpu_address;
        logic [63:0] region_size;
        logic [31:0] write_back_low;
        logic        is_wide;
    } bsw_out_t;

    // Outcome of one window placement attempt
    typedef struct packed {
        logic        ok;
        logic [63:0] addr;
        logic [63:0] next;
    } bsw_fit_t;

endpackage

`default_nettype wire

// ===== sv/bsw_fit.sv =====
// Placement of one naturally aligned block in one memory window.
// Combinational: align the next-free pointer, add the size, compare to the window end.
// Depends on bsw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bsw_fit (
    input  wire logic [63:0]      next_free,
    input  wire logic [63:0]      pci_base,
    input  wire logic [63:0]      length,
    input  wire logic [63:0]      size,
    output bsw_pkg::bsw_fit_t     fit
);
    import bsw_pkg::*;

    logic [63:0] size_m1;
    logic [64:0] align_sum;
    logic [63:0] aligned;
    logic [64:0] block_end;
    logic [64:0] win_end;

    // Round the pointer up to the block size; a carry out means no fit
    always_comb begin
        size_m1   = size - 64'd1;
        align_sum = {1'b0, next_free} + {1'b0, size_m1};
        aligned   = align_sum[63:0] & ~size_m1;
        block_end = {1'b0, aligned} + {1'b0, size};
        win_end   = {1'b0, pci_base} + {1'b0, length};
    end

    // Compare exact 65-bit sums against the window end
    always_comb begin
        fit.ok   = (length != 64'd0) && !align_sum[64] && (block_end <= win_end);
        fit.addr = aligned;
        fit.next = block_end[63:0];
    end

endmodule

`default_nettype wire

// ===== sv/bar_size_window_allocator_top.sv =====
// A beat accepted into the input register moves to the result register, and onto
// m_*, when the result register is free or draining. Throughput: one beat per
// cycle unless m_ready stalls a full result register; the next-free pointers
// update as a beat moves to the result register, in time for the next beat.
// Reset (aresetn low, synchronous): both registers empty, window registers
// and next-free pointers cleared to zero.
// Depends on bsw_pkg and bsw_fit.
`timescale 1ns / 1ps
`default_nettype none

module bar_size_window_allocator_top (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire bsw_pkg::bsw_in_t              s_data,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output bsw_pkg::bsw_out_t                  m_data,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [bsw_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [63:0]                   cfg_data
);
    import bsw_pkg::*;

    logic        in_valid_reg;
    bsw_in_t     in_data_reg;
    logic        out_valid_reg;
    bsw_out_t    out_data_reg;

    logic [63:0] win32_cpu_base_reg;
    logic [63:0] win32_pci_base_reg;
    logic [63:0] win32_length_reg;
    logic [63:0] win64_cpu_base_reg;
    logic [63:0] win64_pci_base_reg;
    logic [63:0] win64_length_reg;
    logic [63:0] next_free_32_reg;
    logic [63:0] next_free_64_reg;
    logic [63:0] next_free_32_next;
    logic [63:0] next_free_64_next;

    logic        advance;
    logic        cfg_wr;
    logic        absent;
    logic        is64;
    logic [63:0] mask;
    logic [63:0] size;
    bsw_fit_t    fit32;
    bsw_fit_t    fit64;
    bsw_out_t    result;

    // Move a beat forward when the result register is free or being drained
    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_data_reg;
    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    // Classify the register and decode its size
    always_comb begin
        absent = (in_data_reg.probe_low == 32'd0) || (in_data_reg.probe_low == '1);
        is64   = (in_data_reg.type_bits[2:1] == MEM_TYPE_64);
        mask   = {(is64 ? in_data_reg.probe_high : 32'hFFFF_FFFF),
                  in_data_reg.probe_low[31:4], 4'b0000};
        size   = ~mask + 64'd1;
    end

    bsw_fit u_fit32 (
        .next_free (next_free_32_reg),
        .pci_base  (win32_pci_base_reg),
        .length    (win32_length_reg),
        .size      (size),
        .fit       (fit32)
    );

    bsw_fit u_fit64 (
        .next_free (next_free_64_reg),
        .pci_base  (win64_pci_base_reg),
        .length    (win64_length_reg),
        .size      (size),
        .fit       (fit64)
    );

    // Pick a window, build the result and the pointer updates
    always_comb begin
        result            = '0;
        next_free_32_next = next_free_32_reg;
        next_free_64_next = next_free_64_reg;
        if (absent) begin
            result.status = ST_ABSENT;
        end else if (in_data_reg.type_bits[0]) begin
            result.status = ST_IO;
        end else begin
            result.status      = ST_NOROOM;
            result.region_size = size;
            result.is_wide     = is64;
            if (size != 64'd0) begin
                if (fit32.ok) begin
                    next_free_32_next = fit32.next;
                    if (fit32.addr != 64'd0) begin
                        result.status      = ST_WIN32;
                        result.pci_address = fit32.addr;
                        result.cpu_address = win32_cpu_base_reg
                                           + (fit32.addr - win32_pci_base_reg);
                    end
                end else if (is64 && fit64.ok) begin
                    next_free_64_next = fit64.next;
                    if (fit64.addr != 64'd0) begin
                        result.status      = ST_WIN64;
                        result.pci_address = fit64.addr;
                        result.cpu_address = win64_cpu_base_reg
                                           + (fit64.addr - win64_pci_base_reg);
                    end
                end
            end
            if (result.status == ST_WIN32 || result.status == ST_WIN64) begin
                result.write_back_low = result.pci_address[31:0]
                                      | {28'd0, in_data_reg.type_bits};
            end
        end
    end

    // Hold control state: valid flags, window registers, next-free pointers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg       <= 1'b0;
            out_valid_reg      <= 1'b0;
            win32_cpu_base_reg <= '0;
            win32_pci_base_reg <= '0;
            win32_length_reg   <= '0;
            win64_cpu_base_reg <= '0;
            win64_pci_base_reg <= '0;
            win64_length_reg   <= '0;
            next_free_32_reg   <= '0;
            next_free_64_reg   <= '0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            // Reload a pointer on a base write, else bump it with the beat
            if (cfg_wr && cfg_index == CFG_WIN32_PCI_BASE) begin
                next_free_32_reg <= cfg_data;
            end else if (advance) begin
                next_free_32_reg <= next_free_32_next;
            end
            if (cfg_wr && cfg_index == CFG_WIN64_PCI_BASE) begin
                next_free_64_reg <= cfg_data;
            end else if (advance) begin
                next_free_64_reg <= next_free_64_next;
            end
            if (cfg_wr) begin
                case (cfg_index)
                    CFG_WIN32_CPU_BASE: win32_cpu_base_reg <= cfg_data;
                    CFG_WIN32_PCI_BASE: win32_pci_base_reg <= cfg_data;
                    CFG_WIN32_LENGTH:   win32_length_reg   <= cfg_data;
                    CFG_WIN64_CPU_BASE: win64_cpu_base_reg <= cfg_data;
                    CFG_WIN64_PCI_BASE: win64_pci_base_reg <= cfg_data;
                    CFG_WIN64_LENGTH:   win64_length_reg   <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // Capture payloads
    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_data_reg <= s_data;
        end
        if (advance) begin
            out_data_reg <= result;
        end
    end

`ifndef SYNTHESIS
    // An address is reported only for a granted window
    a_addr_only_granted: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !(m_data.status == ST_WIN32 || m_data.status == ST_WIN64))
        |-> (m_data.pci_address == 64'd0 && m_data.write_back_low == 32'd0))
        else $error("address reported without a grant");

    // Absent registers carry no size
    a_absent_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status == ST_ABSENT)
        |-> (m_data.region_size == 64'd0 && !m_data.is_wide))
        else $error("absent register with size or width");

    // An empty result register never stalls the input
    a_no_false_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty result register");

    // Pointers move only on an advancing beat or a configuration write
    a_next32_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        (!advance && !cfg_wr) |=> $stable(next_free_32_reg))
        else $error("next_free_32 moved without a beat");
`endif

endmodule

`default_nettype wire

// ===== sim/bar_size_window_allocator_checker.sv =====
// Checker for the BAR sizing and window allocator: watches the config, input
// and result channels, predicts each result beat and compares it in order.
// Depends on bsw_pkg.
`timescale 1ns / 1ps

module bar_size_window_allocator_checker (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    input  wire logic                          s_ready,
    input  wire bsw_pkg::bsw_in_t              s_data,
    input  wire logic                          m_valid,
    input  wire logic                          m_ready,
    input  wire bsw_pkg::bsw_out_t             m_data,
    input  wire logic                          cfg_valid,
    input  wire logic                          cfg_ready,
    input  wire logic [bsw_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [63:0]                   cfg_data,
    output int                                 mismatches,
    output int                                 outstanding
);
    import bsw_pkg::*;

    localparam int MAX_REPORTS = 10;

    // Predicted result beats, oldest first
    bsw_out_t placements_due[$];

    // Shadow of the window registers and the two bump pointers
    logic [63:0] cpu32_base, pci32_base, len32;
    logic [63:0] cpu64_base, pci64_base, len64;
    logic [63:0] ptr32, ptr64;

    // Place a block of size bytes at the first aligned address at or after ptr.
    // All sums are taken one bit wider so that wraps are seen exactly.
    function automatic bsw_fit_t fit_window(input logic [63:0] ptr, input logic [63:0] base,
                                            input logic [63:0] len, input logic [63:0] size);
        logic [64:0] bumped;
        logic [64:0] block_end;
        logic [64:0] window_end;
        logic [63:0] aligned;
        bsw_fit_t    fit;
        fit = '0;
        bumped = {1'b0, ptr} + {1'b0, size - 64'd1};
        if (bumped[64])
            return fit;
        aligned    = bumped[63:0] & ~(size - 64'd1);
        block_end  = {1'b0, aligned} + {1'b0, size};
        window_end = {1'b0, base} + {1'b0, len};
        if (block_end > window_end)
            return fit;
        fit.ok   = 1'b1;
        fit.addr = aligned;
        fit.next = block_end[63:0];
        return fit;
    endfunction

    // Size one probed BAR and allocate it; advances the bump pointers.
    function automatic bsw_out_t size_and_place(input bsw_in_t bar);
        bsw_out_t    res;
        bsw_fit_t    fit;
        logic        wide;
        logic [63:0] mask;
        res = '0;
        fit = '0;
        if (bar.probe_low == '0 || bar.probe_low == '1) begin
            res.status = ST_ABSENT;
        end else if (bar.type_bits[0]) begin
            res.status = ST_IO;
        end else begin
            wide = (bar.type_bits[2:1] == MEM_TYPE_64);
            mask = {(wide ? bar.probe_high : 32'hFFFF_FFFF), bar.probe_low[31:4], 4'h0};
            res.region_size = ~mask + 64'd1;
            res.is_wide     = wide;
            res.status      = ST_NOROOM;
            if (res.region_size != '0) begin
                if (len32 != '0)
                    fit = fit_window(ptr32, pci32_base, len32, res.region_size);
                if (fit.ok) begin
                    // a grant at address zero still moves the pointer
                    ptr32 = fit.next;
                    if (fit.addr != '0) begin
                        res.status      = ST_WIN32;
                        res.pci_address = fit.addr;
                        res.cpu_address = cpu32_base + (fit.addr - pci32_base);
                    end
                end else if (wide && len64 != '0) begin
                    fit = fit_window(ptr64, pci64_base, len64, res.region_size);
                    if (fit.ok) begin
                        ptr64 = fit.next;
                        if (fit.addr != '0) begin
                            res.status      = ST_WIN64;
                            res.pci_address = fit.addr;
                            res.cpu_address = cpu64_base + (fit.addr - pci64_base);
                        end
                    end
                end
            end
            if (res.status == ST_WIN32 || res.status == ST_WIN64)
                res.write_back_low = res.pci_address[31:0] | {28'h0, bar.type_bits};
        end
        return res;
    endfunction

    always @(posedge aclk) begin
        bsw_out_t due;
        if (!aresetn) begin
            cpu32_base  = '0;
            pci32_base  = '0;
            len32       = '0;
            cpu64_base  = '0;
            pci64_base  = '0;
            len64       = '0;
            ptr32       = '0;
            ptr64       = '0;
            mismatches  = 0;
            placements_due.delete();
        end else begin
            // Mirror register writes; unknown indexes are dropped
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_WIN32_CPU_BASE: cpu32_base = cfg_data;
                    CFG_WIN32_PCI_BASE: begin
                        pci32_base = cfg_data;
                        ptr32      = cfg_data;
                    end
                    CFG_WIN32_LENGTH:   len32 = cfg_data;
                    CFG_WIN64_CPU_BASE: cpu64_base = cfg_data;
                    CFG_WIN64_PCI_BASE: begin
                        pci64_base = cfg_data;
                        ptr64      = cfg_data;
                    end
                    CFG_WIN64_LENGTH:   len64 = cfg_data;
                    default: ;
                endcase
            end

            // Check a result beat against the oldest prediction
            if (m_valid && m_ready) begin
                if (placements_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: result beat with nothing predicted: status %0d pci %h",
                                 $realtime, m_data.status, m_data.pci_address);
                end else begin
                    due = placements_due.pop_front();
                    if (m_data !== due) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS) begin
                            $display({"%0t: mismatch, expected status %0d pci %h cpu %h",
                                      " size %h wb %h wide %0d"},
                                     $realtime, due.status, due.pci_address,
                                     due.cpu_address, due.region_size,
                                     due.write_back_low, due.is_wide);
                            $display({"%0t:           actual   status %0d pci %h cpu %h",
                                      " size %h wb %h wide %0d"},
                                     $realtime, m_data.status, m_data.pci_address,
                                     m_data.cpu_address, m_data.region_size,
                                     m_data.write_back_low, m_data.is_wide);
                        end
                    end
                end
            end

            // Predict the result of an accepted BAR beat
            if (s_valid && s_ready)
                placements_due.push_back(size_and_place(s_data));
        end
        outstanding = placements_due.size();
    end

endmodule

// ===== sim/tb_bar_size_window_allocator_top.sv =====
// Testbench top for bar_size_window_allocator_top: clock, reset, window setup,
// BAR beat stimulus, result back-pressure and the verdict.
// Depends on bsw_pkg, the block and bar_size_window_allocator_checker.
`timescale 1ns / 1ps

module tb_bar_size_window_allocator_top;
    import bsw_pkg::*;

    localparam int          BARS_PER_PHASE = 280;
    localparam int          PHASES         = 6;
    localparam int unsigned CYCLE_LIMIT    = 200000;
    localparam int          HOLD_AFTER     = 350;
    localparam int          HOLD_CYCLES    = 300;

    logic                 aclk;
    logic                 aresetn   = 1'b0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    bsw_in_t              s_data    = '0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    bsw_out_t             m_data;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [63:0]          cfg_data  = '0;

    int mismatches;
    int outstanding;
    int bars_sent = 0;

    bar_size_window_allocator_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    bar_size_window_allocator_checker u_alloc_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Watchdog
    initial begin
        int unsigned cycles;
        cycles = 0;
        forever begin
            @(posedge aclk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("bar_size_window_allocator_top test failed");
                $finish;
            end
        end
    end

    // Result back-pressure: rotate through open, random and mostly-stalled
    // stretches, and hold off once for a long stretch while beats keep coming
    initial begin
        int unsigned cyc;
        bit          held_once;
        cyc       = 0;
        held_once = 1'b0;
        forever begin
            @(negedge aclk);
            cyc++;
            if (!held_once && bars_sent >= HOLD_AFTER) begin
                held_once = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end else begin
                case ((cyc / 80) % 3)
                    0:       m_ready <= 1'b1;
                    1:       m_ready <= 1'($urandom_range(0, 1));
                    default: m_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic bsw_in_t bar_of(input logic [3:0] type_bits, input logic [31:0] lo,
                                       input logic [31:0] hi);
        bsw_in_t b;
        b.type_bits  = type_bits;
        b.probe_low  = lo;
        b.probe_high = hi;
        return b;
    endfunction

    // Mostly well-formed memory BARs with power-of-two sizes, the rest raw noise
    function automatic bsw_in_t random_bar();
        bsw_in_t     b;
        logic        wide;
        int unsigned order;
        logic [63:0] mask;
        b.type_bits  = 4'($urandom);
        b.probe_low  = $urandom;
        b.probe_high = $urandom;
        if ($urandom_range(0, 9) < 7) begin
            wide = 1'($urandom_range(0, 1));
            b.type_bits[0] = 1'b0;
            if (wide)
                b.type_bits[2:1] = MEM_TYPE_64;
            else if (b.type_bits[2:1] == MEM_TYPE_64)
                b.type_bits[2] = 1'b0;    // fall back to a plain 32-bit type
            order = ($urandom_range(0, 9) == 0) ? $urandom_range(21, wide ? 44 : 32)
                                                : $urandom_range(4, 20);
            mask = ~((64'd1 << order) - 64'd1);
            b.probe_low = {mask[31:4], b.type_bits};
            if (wide)
                b.probe_high = mask[63:32];
        end
        return b;
    endfunction

    // Offer one BAR beat and hold it until accepted
    task automatic push_bar(input bsw_in_t bar);
        s_data  <= bar;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        bars_sent++;
        @(negedge aclk);
    endtask

    // Leaves cfg_valid high; the caller drops it after the last write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] value);
        cfg_index <= idx;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
    endtask

    task automatic set_windows(input logic [63:0] cpu32, input logic [63:0] pci32,
                               input logic [63:0] len32, input logic [63:0] cpu64,
                               input logic [63:0] pci64, input logic [63:0] len64);
        write_reg(CFG_WIN32_LENGTH, len32);
        write_reg(CFG_WIN32_CPU_BASE, cpu32);
        write_reg(CFG_WIN32_PCI_BASE, pci32);
        write_reg(CFG_WIN64_PCI_BASE, pci64);
        write_reg(CFG_WIN64_CPU_BASE, cpu64);
        write_reg(CFG_WIN64_LENGTH, len64);
    endtask

    // Bursts of back-to-back beats with random gaps between them
    task automatic send_random(input int count);
        int burst;
        int gap;
        int n;
        n = 0;
        while (n < count) begin
            burst = $urandom_range(1, 24);
            for (int k = 0; k < burst && n < count; k++) begin
                push_bar(random_bar());
                n++;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        s_valid <= 1'b0;
    endtask

    // Let every predicted beat drain, then let the pipeline settle
    task automatic drain();
        while (outstanding != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // 32-bit window starts at PCI zero so the first grant lands on address zero
        set_windows(64'h0000_0000_E000_0000, 64'h0, 64'h0000_0000_0100_0000,
                    64'h0000_0080_0000_0000, 64'h0000_0008_0000_0000,
                    64'h0000_0040_0000_0000);
        cfg_valid <= 1'b0;
        @(negedge aclk);

        // Absent registers: readback of zero and of all ones
        push_bar(bar_of(4'h0, 32'h0000_0000, 32'hFFFF_FFFF));
        push_bar(bar_of(4'hF, 32'hFFFF_FFFF, 32'h0000_0000));
        // I/O registers
        push_bar(bar_of(4'h1, 32'hFFFF_FF01, 32'h0000_0000));
        push_bar(bar_of(4'hF, 32'hFFFF_FFFD, 32'hFFFF_FFFF));
        // 4 KiB twice: the first is granted address zero and reports no room
        push_bar(bar_of(4'h0, 32'hFFFF_F000, 32'h0000_0000));
        push_bar(bar_of(4'h0, 32'hFFFF_F000, 32'h0000_0000));
        push_bar(bar_of(4'h8, 32'hFFFF_0008, 32'h5A5A_5A5A));
        // Zero decoded size on 64-bit registers
        push_bar(bar_of(4'h4, 32'h0000_0005, 32'h0000_0000));
        push_bar(bar_of(4'hC, 32'h0000_000C, 32'h0000_0000));
        push_bar(bar_of(4'h4, 32'h0000_0004, 32'h0000_0000));
        // 64 GiB only fits the 64-bit window
        push_bar(bar_of(4'hC, 32'h0000_000C, 32'hFFFF_FFF0));
        // Smallest memory size
        push_bar(bar_of(4'h4, 32'hFFFF_FFF4, 32'hFFFF_FFFF));
        // Legacy and reserved type fields decode as 32-bit
        push_bar(bar_of(4'h2, 32'hFFE0_0002, 32'h0000_0000));
        push_bar(bar_of(4'h6, 32'hFFF0_0006, 32'h1234_5678));
        push_bar(bar_of(4'hE, 32'h8000_000E, 32'hFFFF_FFFF));
        // 4 GiB: a 32-bit register has nowhere to go, a 64-bit one moves up
        push_bar(bar_of(4'h0, 32'h0000_0008, 32'hFFFF_FFFF));
        push_bar(bar_of(4'h4, 32'h0000_0004, 32'hFFFF_FFFF));
        // 2^63 fits neither window
        push_bar(bar_of(4'h4, 32'h0000_0004, 32'h8000_0000));
        // 16 MiB: 32-bit window too full, 64-bit register falls through
        push_bar(bar_of(4'h0, 32'hFF00_0000, 32'h0000_0000));
        push_bar(bar_of(4'h4, 32'hFF00_0004, 32'hFFFF_FFFF));
        push_bar(bar_of(4'hC, 32'hFFFF_FF0C, 32'hFFFF_FFFF));
        s_valid <= 1'b0;

        send_random(BARS_PER_PHASE);
        drain();

        for (int ph = 1; ph < PHASES; ph++) begin
            case (ph)
                1: begin
                    // No windows at all; also poke the unused indexes
                    set_windows('0, '0, '0, '0, '0, '0);
                    for (int i = int'(CFG_WIN64_LENGTH) + 1; i < 2 ** CFG_IDX_W; i++)
                        write_reg(CFG_IDX_W'(i), rand64());
                end
                2: begin
                    // Top of the address space: alignment carries and window-end wraps
                    set_windows('1, '1, '1, '1, 64'hFFFF_FFFF_F000_0000, '1);
                end
                3: begin
                    // Tiny 32-bit window at the very top; its pointer wraps to zero
                    set_windows(rand64(), 64'hFFFF_FFFF_FFFF_FFF0, 64'h10, rand64(),
                                {32'h0, $urandom} & ~64'hFFF, 64'h0000_0100_0000_0000);
                end
                default: begin
                    set_windows(rand64(), {32'h0, $urandom & 32'hFFFF_F000},
                                64'd1 << $urandom_range(20, 28), rand64(), rand64(),
                                rand64());
                end
            endcase
            cfg_valid <= 1'b0;
            @(negedge aclk);
            send_random(BARS_PER_PHASE);
            drain();
        end

        while (outstanding != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
        if (mismatches == 0 && outstanding == 0)
            $display("bar_size_window_allocator_top test passed");
        else
            $display("bar_size_window_allocator_top test failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/bsw_pkg.sv
sv/bsw_fit.sv
sv/bar_size_window_allocator_top.sv
sim/bar_size_window_allocator_checker.sv
sim/tb_bar_size_window_allocator_top.sv
